// ===== hdl/ansi_escape_filter_unit_macros.svh =====
// Assertion macros for the filter RTL.
// AEF_ASSERT checks only outside reset; AEF_ASSERT_ALWAYS checks every edge.
`ifndef ANSI_ESCAPE_FILTER_UNIT_MACROS_SVH
`define ANSI_ESCAPE_FILTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define AEF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AEF_ASSERT(lbl, clk, rst, prop, msg)
`define AEF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/aef_pkg.sv =====
// ----------------------------------------------------------------------------
// aef_pkg
// Types, character codes and helpers for the terminal escape filter.
// ----------------------------------------------------------------------------
package aef_pkg;

  localparam int unsigned MAX_SEQ   = 1024;
  localparam int unsigned SEQ_W     = $clog2(MAX_SEQ) + 1;
  // last sequence length at which parameter bytes are still scanned
  localparam int unsigned SCAN_LAST = 199;

  localparam logic [7:0] CH_BEL   = 8'd7;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SO    = 8'd14;
  localparam logic [7:0] CH_SI    = 8'd15;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_M     = 8'h6D;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_CTRL  = 2'd1,
    KIND_INSEQ = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    MODE_GROUND = 4'b0001,
    MODE_ESC    = 4'b0010,
    MODE_CSI    = 4'b0100,
    MODE_OSC    = 4'b1000
  } mode_t;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_PLUS   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_AFTER  = 5'b01000,
    PH_DEAD   = 5'b10000
  } phase_t;

  typedef struct packed {
    mode_t             mode;
    logic [SEQ_W-1:0]  seq_len;
    logic [7:0]        field_value;
    phase_t            phase;
    logic              any_one;
    logic              bold;
    logic              shift;
  } parse_state_t;

  localparam parse_state_t ST_RESET = '{
    mode:        MODE_GROUND,
    seq_len:     '0,
    field_value: 8'd0,
    phase:       PH_START,
    any_one:     1'b0,
    bold:        1'b0,
    shift:       1'b0
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       bold;
    logic       shifted_in;
    logic       beep;
    logic       warning;
    logic       overflow;
  } result_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // CSI finals that are dropped without a warning
  function automatic logic is_quiet_final(input logic [7:0] b);
    logic q;
    q = 1'b0;
    unique case (b)
      8'h4B, 8'h48, 8'h66, 8'h4A, 8'h41, 8'h42, 8'h43, 8'h44,
      8'h73, 8'h75, 8'h68, 8'h72, 8'h6C, 8'h64, 8'h47, 8'h58: q = 1'b1;
      default: q = 1'b0;
    endcase
    return q;
  endfunction

endpackage

// ===== hdl/aef_in_if.sv =====
// ----------------------------------------------------------------------------
// aef_in_if
// Byte stream channel into the filter.
// ----------------------------------------------------------------------------
interface aef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hdl/aef_out_if.sv =====
// ----------------------------------------------------------------------------
// aef_out_if
// Result channel out of the filter, one word per input byte.
// ----------------------------------------------------------------------------
interface aef_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       bold;
  logic       shifted_in;
  logic       beep;
  logic       warning;
  logic       overflow;

  modport source (output valid, output kind, output out_byte, output bold,
                  output shifted_in, output beep, output warning,
                  output overflow, input ready);
  modport sink (input valid, input kind, input out_byte, input bold,
                input shifted_in, input beep, input warning,
                input overflow, output ready);
endinterface

// ===== hdl/ansi_escape_filter_unit.sv =====
// ----------------------------------------------------------------------------
// ansi_escape_filter_unit
// Terminal byte stream filter: text passthrough, control and escape parsing.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  rx       in   in_byte[7:0]
//  tx       out  kind[1:0] out_byte[7:0] bold shifted_in beep warning overflow
//
//  One byte per cycle sustained while tx is not stalled; a result word is
//  presented once its byte has passed the input register, then the result register.
//  The parse state updates as a byte moves into the result register.
//  rx.ready drops only while both registers are full and tx is stalled.
//  Synchronous reset returns the parser to ground with bold and shift clear.
// ----------------------------------------------------------------------------
`include "ansi_escape_filter_unit_macros.svh"

module ansi_escape_filter_unit (
  input  logic          clk,
  input  logic          rst,
  aef_in_if.sink        rx,
  aef_out_if.source     tx
);

  logic                  in_valid;
  logic [7:0]            in_byte_q;
  logic                  out_valid;
  logic                  advance;
  aef_pkg::parse_state_t st;
  aef_pkg::parse_state_t st_next;
  aef_pkg::result_t      res;
  aef_pkg::result_t      res_q;

  aef_parser u_parser (
    .b       (in_byte_q),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  assign advance  = !out_valid || tx.ready;
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= aef_pkg::ST_RESET;
    end else begin
      if (rx.ready) begin
        in_valid <= rx.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (advance && in_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte_q <= rx.in_byte;
    end
    if (advance && in_valid) begin
      res_q <= res;
    end
  end

  assign tx.valid      = out_valid;
  assign tx.kind       = res_q.kind;
  assign tx.out_byte   = res_q.out_byte;
  assign tx.bold       = res_q.bold;
  assign tx.shifted_in = res_q.shifted_in;
  assign tx.beep       = res_q.beep;
  assign tx.warning    = res_q.warning;
  assign tx.overflow   = res_q.overflow;

  `AEF_ASSERT(a_ovf_ends, clk, rst,
    tx.valid && tx.overflow |-> tx.kind == aef_pkg::KIND_END,
    "overflow without sequence end")
  `AEF_ASSERT(a_beep_ctrl, clk, rst,
    tx.valid && tx.beep |-> tx.kind == aef_pkg::KIND_CTRL,
    "beep outside a control byte")
  `AEF_ASSERT(a_byte_text, clk, rst,
    tx.valid && tx.kind != aef_pkg::KIND_TEXT |-> tx.out_byte == 8'd0,
    "out_byte set on a non-text word")
  `AEF_ASSERT(a_ground_len, clk, rst,
    st.mode == aef_pkg::MODE_GROUND |-> st.seq_len == '0,
    "sequence length left over in ground")
  `AEF_ASSERT_ALWAYS(a_ready_free, clk, !rst && !out_valid |-> rx.ready,
    "input stalled with result register empty")

endmodule

// ===== hdl/aef_field_scan.sv =====
// ----------------------------------------------------------------------------
// aef_field_scan
// Scans one CSI parameter byte: sign, saturating decimal value, ';' close.
// ----------------------------------------------------------------------------
module aef_field_scan (
  input  logic [7:0]      b,
  input  aef_pkg::phase_t phase,
  input  logic [7:0]      field_value,
  input  logic            any_one,
  output aef_pkg::phase_t phase_next,
  output logic [7:0]      field_value_next,
  output logic            any_one_next,
  output logic            field_is_one
);

  logic        digit;
  logic [3:0]  d;
  logic [11:0] acc;

  assign digit = (b >= aef_pkg::CH_ZERO) && (b <= aef_pkg::CH_NINE);
  assign d     = digit ? 4'(b - aef_pkg::CH_ZERO) : 4'd0;
  assign acc   = 12'(field_value) * 12'd10 + 12'(d);

  assign field_is_one = ((phase == aef_pkg::PH_DIGITS) || (phase == aef_pkg::PH_AFTER))
                        && (field_value == 8'd1);

  always_comb begin
    phase_next       = phase;
    field_value_next = field_value;
    any_one_next     = any_one;
    if (b == aef_pkg::CH_SEMI) begin
      any_one_next     = any_one | field_is_one;
      phase_next       = aef_pkg::PH_START;
      field_value_next = 8'd0;
    end else begin
      unique case (phase)
        aef_pkg::PH_START: begin
          priority if (aef_pkg::is_space(b)) begin
            phase_next = aef_pkg::PH_START;
          end else if (b == aef_pkg::CH_PLUS) begin
            phase_next = aef_pkg::PH_PLUS;
          end else if (digit) begin
            field_value_next = 8'(d);
            phase_next       = aef_pkg::PH_DIGITS;
          end else begin
            phase_next = aef_pkg::PH_DEAD;
          end
        end
        aef_pkg::PH_PLUS: begin
          if (digit) begin
            field_value_next = 8'(d);
            phase_next       = aef_pkg::PH_DIGITS;
          end else begin
            phase_next = aef_pkg::PH_DEAD;
          end
        end
        aef_pkg::PH_DIGITS: begin
          if (digit) begin
            field_value_next = (acc > 12'd255) ? 8'hFF : acc[7:0];
          end else begin
            phase_next = aef_pkg::PH_AFTER;
          end
        end
        aef_pkg::PH_AFTER, aef_pkg::PH_DEAD: begin
          phase_next = phase;
        end
        default: begin
          phase_next = aef_pkg::PH_DEAD;
        end
      endcase
    end
  end

endmodule

// ===== hdl/aef_parser.sv =====
// ----------------------------------------------------------------------------
// aef_parser
// Next parse state and result word for one byte against the current state.
// ----------------------------------------------------------------------------
module aef_parser (
  input  logic [7:0]            b,
  input  aef_pkg::parse_state_t st,
  output aef_pkg::parse_state_t st_next,
  output aef_pkg::result_t      res
);

  aef_pkg::phase_t          scan_phase;
  logic [7:0]               scan_value;
  logic                     scan_any_one;
  logic                     field_is_one;
  logic [aef_pkg::SEQ_W-1:0] len_inc;
  logic                     scan_en;

  aef_field_scan u_scan (
    .b                (b),
    .phase            (st.phase),
    .field_value      (st.field_value),
    .any_one          (st.any_one),
    .phase_next       (scan_phase),
    .field_value_next (scan_value),
    .any_one_next     (scan_any_one),
    .field_is_one     (field_is_one)
  );

  assign len_inc = st.seq_len + 1'b1;
  assign scan_en = (32'(st.seq_len) >= 32'd2) && (32'(st.seq_len) <= aef_pkg::SCAN_LAST);

  always_comb begin
    st_next      = st;
    res.kind     = aef_pkg::KIND_TEXT;
    res.out_byte = 8'd0;
    res.beep     = 1'b0;
    res.warning  = 1'b0;
    res.overflow = 1'b0;
    unique case (st.mode)
      aef_pkg::MODE_GROUND: begin
        priority if ((b >= aef_pkg::CH_SPACE) || (b == aef_pkg::CH_LF)) begin
          res.kind     = aef_pkg::KIND_TEXT;
          res.out_byte = st.shift ? aef_pkg::CH_QMARK : b;
        end else if (b == aef_pkg::CH_ESC) begin
          res.kind        = aef_pkg::KIND_INSEQ;
          st_next.mode    = aef_pkg::MODE_ESC;
          st_next.seq_len = aef_pkg::SEQ_W'(1);
        end else begin
          res.kind = aef_pkg::KIND_CTRL;
          priority if (b == aef_pkg::CH_BEL) begin
            res.beep = 1'b1;
          end else if (b == aef_pkg::CH_SI) begin
            st_next.shift = 1'b1;
          end else if ((b != aef_pkg::CH_BS) && (b != aef_pkg::CH_TAB) &&
                       (b != aef_pkg::CH_CR) && (b != aef_pkg::CH_SO)) begin
            res.warning = 1'b1;
          end else begin
            res.warning = 1'b0;
          end
        end
      end
      aef_pkg::MODE_ESC: begin
        st_next.seq_len = aef_pkg::SEQ_W'(2);
        priority if (b == aef_pkg::CH_LBRK) begin
          res.kind            = aef_pkg::KIND_INSEQ;
          st_next.mode        = aef_pkg::MODE_CSI;
          st_next.field_value = 8'd0;
          st_next.phase       = aef_pkg::PH_START;
          st_next.any_one     = 1'b0;
        end else if (b == aef_pkg::CH_RBRK) begin
          res.kind     = aef_pkg::KIND_INSEQ;
          st_next.mode = aef_pkg::MODE_OSC;
        end else begin
          res.kind        = aef_pkg::KIND_END;
          st_next.mode    = aef_pkg::MODE_GROUND;
          st_next.seq_len = '0;
        end
      end
      aef_pkg::MODE_CSI, aef_pkg::MODE_OSC: begin
        priority if ((st.mode == aef_pkg::MODE_CSI) && aef_pkg::is_letter(b)) begin
          res.kind        = aef_pkg::KIND_END;
          st_next.mode    = aef_pkg::MODE_GROUND;
          st_next.seq_len = '0;
          if (b == aef_pkg::CH_M) begin
            // close the open field, then bold follows the collected flag
            st_next.any_one     = st.any_one | field_is_one;
            st_next.phase       = aef_pkg::PH_START;
            st_next.field_value = 8'd0;
            st_next.bold        = st.any_one | field_is_one;
          end else begin
            res.warning = !aef_pkg::is_quiet_final(b);
          end
        end else if ((st.mode == aef_pkg::MODE_OSC) && (b == aef_pkg::CH_BEL)) begin
          res.kind        = aef_pkg::KIND_END;
          st_next.mode    = aef_pkg::MODE_GROUND;
          st_next.seq_len = '0;
        end else begin
          if ((st.mode == aef_pkg::MODE_CSI) && scan_en) begin
            st_next.phase       = scan_phase;
            st_next.field_value = scan_value;
            st_next.any_one     = scan_any_one;
          end
          if (32'(len_inc) >= aef_pkg::MAX_SEQ) begin
            // drop an overlong sequence
            res.kind        = aef_pkg::KIND_END;
            res.overflow    = 1'b1;
            st_next.mode    = aef_pkg::MODE_GROUND;
            st_next.seq_len = '0;
          end else begin
            res.kind        = aef_pkg::KIND_INSEQ;
            st_next.seq_len = len_inc;
          end
        end
      end
      default: begin
        st_next.mode    = aef_pkg::MODE_GROUND;
        st_next.seq_len = '0;
      end
    endcase
    res.bold       = st_next.bold;
    res.shifted_in = st_next.shift;
  end

endmodule

// ===== tb/ansi_escape_filter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ansi_escape_filter_unit_tb
// Drives a terminal byte stream into the escape filter and checks every result
// word against a cycle-free model of the parser. A short table covers text
// extremes, control codes and each sequence type, then random well-formed
// sequences with noise and one sequence that runs into the length limit
// follow. Both channels stall at random.
// ----------------------------------------------------------------------------
module ansi_escape_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_PCT    = 14;
  localparam int RANDOM_BYTES = 1900;
  localparam int HANG_LIMIT   = 2000;
  localparam int SETTLE_CYC   = 10;
  localparam int QUIET_FROM   = 600;
  localparam int QUIET_TO     = 1400;

  localparam logic [4:0] F_BOLD = 5'b10000;
  localparam logic [4:0] F_BEEP = 5'b00100;
  localparam logic [4:0] F_WARN = 5'b00010;

  typedef struct packed {
    logic [7:0]       code;
    logic             typed;
    aef_pkg::result_t want;
  } stim_t;

  logic clk;
  logic rst;

  aef_in_if  rx_ch ();
  aef_out_if tx_ch ();

  ansi_escape_filter_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch)
  );

  always #5 clk = ~clk;

  // parser state mirrored by the checker
  aef_pkg::mode_t            p_mode;
  logic [aef_pkg::SEQ_W-1:0] p_len;
  logic [7:0]                p_val;
  aef_pkg::phase_t           p_phase;
  logic                      p_any;
  logic                      p_bold;
  logic                      p_shift;

  logic [7:0] quiet_finals [16] = '{"K", "H", "f", "J", "A", "B", "C", "D",
                                    "s", "u", "h", "r", "l", "d", "G", "X"};

  stim_t            byte_q[$];
  aef_pkg::result_t pending_words[$];
  stim_t            cur_word;
  stim_t            dir_tab [27];
  int               sent;
  int               taken;
  int               errors;
  int               cyc;
  int               hang_cyc;
  int               n_random;
  logic             si_ok;

  function automatic stim_t entry(input logic [7:0] b, input logic typed = 1'b0,
                                  input aef_pkg::kind_t k = aef_pkg::KIND_TEXT,
                                  input logic [7:0] ob = 8'h00,
                                  input logic [4:0] fl = 5'b00000);
    stim_t s;
    s.code  = b;
    s.typed = typed;
    s.want  = {k, ob, fl};
    return s;
  endfunction

  function automatic logic alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic void close_field();
    if ((p_phase == aef_pkg::PH_DIGITS || p_phase == aef_pkg::PH_AFTER) && p_val == 8'd1)
      p_any = 1'b1;
    p_phase = aef_pkg::PH_START;
    p_val   = 8'd0;
  endfunction

  function automatic void scan_param(input logic [7:0] b);
    logic        digit;
    logic [7:0]  d;
    int unsigned v;
    digit = (b >= aef_pkg::CH_ZERO && b <= aef_pkg::CH_NINE);
    d     = digit ? b - aef_pkg::CH_ZERO : 8'd0;
    if (b == aef_pkg::CH_SEMI) begin
      close_field();
    end else begin
      case (p_phase)
        aef_pkg::PH_START: begin
          if (b == aef_pkg::CH_SPACE || (b >= aef_pkg::CH_TAB && b <= aef_pkg::CH_CR)) begin
            p_phase = aef_pkg::PH_START;
          end else if (b == aef_pkg::CH_PLUS) begin
            p_phase = aef_pkg::PH_PLUS;
          end else if (digit) begin
            p_val   = d;
            p_phase = aef_pkg::PH_DIGITS;
          end else begin
            p_phase = aef_pkg::PH_DEAD;
          end
        end
        aef_pkg::PH_PLUS: begin
          if (digit) begin
            p_val   = d;
            p_phase = aef_pkg::PH_DIGITS;
          end else begin
            p_phase = aef_pkg::PH_DEAD;
          end
        end
        aef_pkg::PH_DIGITS: begin
          if (digit) begin
            v     = p_val * 10 + d;
            p_val = (v > 255) ? 8'd255 : v[7:0];
          end else begin
            p_phase = aef_pkg::PH_AFTER;
          end
        end
        default: ;
      endcase
    end
  endfunction

  // returns the warning bit for a CSI final letter
  function automatic logic csi_final(input logic [7:0] b);
    if (b == aef_pkg::CH_M) begin
      close_field();
      p_bold = p_any;
      return 1'b0;
    end
    foreach (quiet_finals[i])
      if (quiet_finals[i] == b) return 1'b0;
    return 1'b1;
  endfunction

  function automatic aef_pkg::result_t filter_byte(input logic [7:0] b);
    aef_pkg::result_t r;
    int unsigned      len;
    r = '0;
    case (p_mode)
      aef_pkg::MODE_GROUND: begin
        if (b >= aef_pkg::CH_SPACE || b == aef_pkg::CH_LF) begin
          r.kind     = aef_pkg::KIND_TEXT;
          r.out_byte = p_shift ? aef_pkg::CH_QMARK : b;
        end else if (b == aef_pkg::CH_ESC) begin
          r.kind = aef_pkg::KIND_INSEQ;
          p_mode = aef_pkg::MODE_ESC;
          p_len  = aef_pkg::SEQ_W'(1);
        end else begin
          r.kind = aef_pkg::KIND_CTRL;
          if (b == aef_pkg::CH_BEL) r.beep = 1'b1;
          else if (b == aef_pkg::CH_SI) p_shift = 1'b1;
          else if (!(b inside {aef_pkg::CH_BS, aef_pkg::CH_TAB, aef_pkg::CH_CR,
                               aef_pkg::CH_SO})) r.warning = 1'b1;
        end
      end
      aef_pkg::MODE_ESC: begin
        p_len = aef_pkg::SEQ_W'(2);
        if (b == aef_pkg::CH_LBRK) begin
          r.kind  = aef_pkg::KIND_INSEQ;
          p_mode  = aef_pkg::MODE_CSI;
          p_val   = 8'd0;
          p_phase = aef_pkg::PH_START;
          p_any   = 1'b0;
        end else if (b == aef_pkg::CH_RBRK) begin
          r.kind = aef_pkg::KIND_INSEQ;
          p_mode = aef_pkg::MODE_OSC;
        end else begin
          r.kind = aef_pkg::KIND_END;
          p_mode = aef_pkg::MODE_GROUND;
          p_len  = '0;
        end
      end
      default: begin
        len = p_len;
        if (p_mode == aef_pkg::MODE_CSI && alpha(b)) begin
          r.kind    = aef_pkg::KIND_END;
          r.warning = csi_final(b);
          p_mode    = aef_pkg::MODE_GROUND;
          p_len     = '0;
        end else if (p_mode == aef_pkg::MODE_OSC && b == aef_pkg::CH_BEL) begin
          r.kind = aef_pkg::KIND_END;
          p_mode = aef_pkg::MODE_GROUND;
          p_len  = '0;
        end else begin
          if (p_mode == aef_pkg::MODE_CSI && len >= 2 && len <= aef_pkg::SCAN_LAST)
            scan_param(b);
          len = len + 1;
          if (len >= aef_pkg::MAX_SEQ) begin
            // drop the sequence
            r.kind     = aef_pkg::KIND_END;
            r.overflow = 1'b1;
            p_mode     = aef_pkg::MODE_GROUND;
            p_len      = '0;
          end else begin
            r.kind = aef_pkg::KIND_INSEQ;
            p_len  = len[aef_pkg::SEQ_W-1:0];
          end
        end
      end
    endcase
    r.bold       = p_bold;
    r.shifted_in = p_shift;
    return r;
  endfunction

  function automatic string word_str(input aef_pkg::result_t w);
    return $sformatf("kind=%0d byte=%02h bold=%b si=%b beep=%b warn=%b ovf=%b",
                     w.kind, w.out_byte, w.bold, w.shifted_in, w.beep, w.warning,
                     w.overflow);
  endfunction

  task automatic flag_error(input string what, input aef_pkg::result_t w,
                            input aef_pkg::result_t g);
    errors++;
    if (errors <= 10)
      $display("%s: expected %s / got %s", what, word_str(w), word_str(g));
  endtask

  // ---- stimulus generation ----

  task automatic add_byte(input logic [7:0] b);
    // hold shift-in back until late, it masks all later text
    if (!si_ok && b == aef_pkg::CH_SI) b = aef_pkg::CH_SO;
    byte_q.push_back(entry(b));
    n_random++;
  endtask

  function automatic logic [7:0] param_byte();
    int unsigned sel;
    logic [7:0]  b;
    sel = $urandom_range(99);
    if (sel < 25) return 8'h31;
    if (sel < 45) return aef_pkg::CH_ZERO + 8'($urandom_range(9));
    if (sel < 60) return aef_pkg::CH_SEMI;
    if (sel < 68) return aef_pkg::CH_SPACE;
    if (sel < 74) return aef_pkg::CH_PLUS;
    if (sel < 79) return 8'h2D;
    if (sel < 82) return aef_pkg::CH_TAB;
    do b = 8'($urandom_range(255)); while (alpha(b));
    return b;
  endfunction

  function automatic logic [7:0] osc_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == aef_pkg::CH_BEL);
    return b;
  endfunction

  task automatic gen_chunk();
    int unsigned sel;
    int unsigned n;
    logic [7:0]  b;
    sel = $urandom_range(99);
    if (sel < 30) begin
      n = $urandom_range(1, 6);
      repeat (n)
        add_byte(($urandom_range(9) == 0) ? aef_pkg::CH_LF : 8'($urandom_range(32, 255)));
    end else if (sel < 40) begin
      do b = 8'($urandom_range(31)); while (b == aef_pkg::CH_ESC);
      add_byte(b);
    end else if (sel < 70) begin
      add_byte(aef_pkg::CH_ESC);
      add_byte(aef_pkg::CH_LBRK);
      n = $urandom_range(0, 8);
      repeat (n) add_byte(param_byte());
      n = $urandom_range(3);
      if (n < 2) begin
        add_byte(aef_pkg::CH_M);
      end else if (n == 2) begin
        add_byte(quiet_finals[$urandom_range(15)]);
      end else begin
        b = 8'($urandom_range(25));
        add_byte($urandom_range(1) ? 8'h41 + b : 8'h61 + b);
      end
    end else if (sel < 80) begin
      add_byte(aef_pkg::CH_ESC);
      add_byte(aef_pkg::CH_RBRK);
      n = $urandom_range(0, 10);
      repeat (n) add_byte(osc_byte());
      add_byte(aef_pkg::CH_BEL);
    end else if (sel < 88) begin
      add_byte(aef_pkg::CH_ESC);
      do b = 8'($urandom_range(255)); while (b == aef_pkg::CH_LBRK || b == aef_pkg::CH_RBRK);
      add_byte(b);
    end else if (sel < 99) begin
      n = $urandom_range(1, 3);
      repeat (n) add_byte(8'($urandom_range(255)));
    end else begin
      // long parameter run around the end of the scanned window
      add_byte(aef_pkg::CH_ESC);
      add_byte(aef_pkg::CH_LBRK);
      n = $urandom_range(190, 205);
      repeat (n) begin
        sel = $urandom_range(9);
        add_byte(sel < 7 ? 8'h32 : (sel < 9 ? aef_pkg::CH_SEMI : aef_pkg::CH_SPACE));
      end
      add_byte(aef_pkg::CH_SEMI);
      add_byte(8'h31);
      add_byte(aef_pkg::CH_M);
    end
  endtask

  // ---- drive at the falling edge ----

  always @(negedge clk) begin
    logic quiet;
    quiet = (cyc >= QUIET_FROM && cyc < QUIET_TO);
    if (rst) begin
      rx_ch.valid  <= 1'b0;
      tx_ch.ready  <= 1'b0;
    end else begin
      if (sent == taken) begin
        if (byte_q.size() != 0 && (quiet || $urandom_range(99) >= STALL_PCT)) begin
          cur_word = byte_q.pop_front();
          rx_ch.valid   <= 1'b1;
          rx_ch.in_byte <= cur_word.code;
          sent++;
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
      tx_ch.ready <= quiet || ($urandom_range(99) >= STALL_PCT);
    end
  end

  // ---- sample at the rising edge ----

  always @(posedge clk) begin
    aef_pkg::result_t got;
    aef_pkg::result_t want;
    logic             moved;
    if (!rst) begin
      cyc++;
      moved = 1'b0;
      if (rx_ch.valid && rx_ch.ready) begin
        want = filter_byte(cur_word.code);
        if (cur_word.typed) want = cur_word.want;
        pending_words.push_back(want);
        taken++;
        moved = 1'b1;
      end
      if (tx_ch.valid && tx_ch.ready) begin
        got = {tx_ch.kind, tx_ch.out_byte, tx_ch.bold, tx_ch.shifted_in, tx_ch.beep,
               tx_ch.warning, tx_ch.overflow};
        if (pending_words.size() == 0) begin
          flag_error("word with nothing pending", '0, got);
        end else begin
          want = pending_words.pop_front();
          if (got !== want) flag_error("word mismatch", want, got);
        end
        moved = 1'b1;
      end
      hang_cyc = moved ? 0 : hang_cyc + 1;
      if (hang_cyc >= HANG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.in_byte = 8'h00;
    tx_ch.ready   = 1'b0;
    sent          = 0;
    taken         = 0;
    errors        = 0;
    cyc           = 0;
    hang_cyc      = 0;
    n_random      = 0;
    si_ok         = 1'b0;
    p_mode        = aef_pkg::MODE_GROUND;
    p_len         = '0;
    p_val         = 8'd0;
    p_phase       = aef_pkg::PH_START;
    p_any         = 1'b0;
    p_bold        = 1'b0;
    p_shift       = 1'b0;

    dir_tab = '{
      entry(8'h41,            1'b1, aef_pkg::KIND_TEXT,  8'h41),
      entry(8'h00,            1'b1, aef_pkg::KIND_CTRL,  8'h00, F_WARN),
      entry(8'hFF,            1'b1, aef_pkg::KIND_TEXT,  8'hFF),
      entry(aef_pkg::CH_LF,   1'b1, aef_pkg::KIND_TEXT,  aef_pkg::CH_LF),
      entry(aef_pkg::CH_BEL,  1'b1, aef_pkg::KIND_CTRL,  8'h00, F_BEEP),
      entry(aef_pkg::CH_BS,   1'b1, aef_pkg::KIND_CTRL),
      entry(8'h1F,            1'b1, aef_pkg::KIND_CTRL,  8'h00, F_WARN),
      entry(aef_pkg::CH_ESC,  1'b1, aef_pkg::KIND_INSEQ),
      entry(aef_pkg::CH_LBRK, 1'b1, aef_pkg::KIND_INSEQ),
      entry(aef_pkg::CH_SPACE),
      entry(aef_pkg::CH_PLUS),
      entry(8'h31),
      entry(aef_pkg::CH_M,    1'b1, aef_pkg::KIND_END,   8'h00, F_BOLD),
      entry(aef_pkg::CH_ESC),
      entry(aef_pkg::CH_RBRK),
      entry(8'h78),
      entry(aef_pkg::CH_BEL,  1'b1, aef_pkg::KIND_END,   8'h00, F_BOLD),
      entry(aef_pkg::CH_ESC),
      entry(8'h63,            1'b1, aef_pkg::KIND_END,   8'h00, F_BOLD),
      entry(aef_pkg::CH_ESC),
      entry(aef_pkg::CH_LBRK),
      entry(8'h2D),
      entry(8'h31),
      entry(aef_pkg::CH_M,    1'b1, aef_pkg::KIND_END),
      entry(aef_pkg::CH_ESC),
      entry(aef_pkg::CH_LBRK),
      entry(8'h71,            1'b1, aef_pkg::KIND_END,   8'h00, F_WARN)
    };
    foreach (dir_tab[i]) byte_q.push_back(dir_tab[i]);

    while (n_random < 300) gen_chunk();
    // CSI that runs into the length limit
    add_byte(aef_pkg::CH_ESC);
    add_byte(aef_pkg::CH_LBRK);
    repeat (aef_pkg::MAX_SEQ - 2) add_byte(param_byte());
    while (n_random < 1500) gen_chunk();
    si_ok = 1'b1;
    add_byte(aef_pkg::CH_SI);
    while (n_random < RANDOM_BYTES) gen_chunk();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || taken != sent) @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    errors += pending_words.size();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/aef_pkg.sv
hdl/aef_in_if.sv
hdl/aef_out_if.sv
hdl/aef_field_scan.sv
hdl/aef_parser.sv
hdl/ansi_escape_filter_unit.sv
tb/ansi_escape_filter_unit_tb.sv
